@@ rtl/k_way_merge_ordered_list_assert.svh @@
// assertion macros for the merge list rtl
`ifndef K_WAY_MERGE_ORDERED_LIST_ASSERT_SVH
`define K_WAY_MERGE_ORDERED_LIST_ASSERT_SVH

`ifndef SYNTHESIS
`define KWM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("merge list check failed");
`define KWM_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("merge list invariant failed");
`else
`define KWM_ASSERT(lbl, clk, rst, prop)
`define KWM_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/kwm_pkg.sv @@
// package with sizes, codes and control types of the merge list
package kwm_pkg;

   localparam int RUNS  = 16;
   localparam int RUN_W = 4;
   localparam int KEY_W = 64;
   localparam int CNT_W = $clog2(RUNS + 1);

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_POP    = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_POPPED   = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic pop;
   } kwm_ctl_type;

endpackage

@@ rtl/kwm_cell.sv @@
// one slot of the ordered list: holds a key and run, shifts with its neighbors
module kwm_cell (
   input  logic                      clock,
   input  kwm_pkg::kwm_ctl_type      ctl,
   input  logic                      slot_valid,
   input  logic [kwm_pkg::KEY_W-1:0] new_key,
   input  logic [kwm_pkg::RUN_W-1:0] new_run,
   input  logic [kwm_pkg::KEY_W-1:0] left_key,
   input  logic [kwm_pkg::RUN_W-1:0] left_run,
   input  logic                      left_after,
   input  logic [kwm_pkg::KEY_W-1:0] right_key,
   input  logic [kwm_pkg::RUN_W-1:0] right_run,
   output logic [kwm_pkg::KEY_W-1:0] key,
   output logic [kwm_pkg::RUN_W-1:0] run,
   output logic                      after
);
   import kwm_pkg::*;

   logic [KEY_W-1:0] key_ff, key_in;
   logic [RUN_W-1:0] run_ff, run_in;

   // new key belongs behind this slot
   assign after = slot_valid && (new_key > key_ff);

   always_comb begin
      key_in = key_ff;
      run_in = run_ff;
      if (ctl.ins) begin
         if (!after) begin
            if (left_after) begin
               key_in = new_key;
               run_in = new_run;
            end else begin
               key_in = left_key;
               run_in = left_run;
            end
         end
      end else if (ctl.pop) begin
         key_in = right_key;
         run_in = right_run;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      run_ff <= run_in;
   end

   assign key = key_ff;
   assign run = run_ff;

endmodule

@@ rtl/k_way_merge_ordered_list.sv @@
// top level of the k-way merge ordered list
// Ordered list of up to RUNS (run, key) entries in a chain of cells, smallest
// key in cell 0. A new item is taken every cycle while the result register is
// free or being drained; the result is registered and appears in the cycle
// after the item is accepted. The cycle time is set by the 64-bit compare in
// each cell, which all cells do in parallel against the broadcast key, and by
// the neighbor select that follows it.
module k_way_merge_ordered_list (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  logic [kwm_pkg::RUN_W-1:0] req_run_id,
   input  logic [kwm_pkg::KEY_W-1:0] req_key,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_status,
   output logic [kwm_pkg::RUN_W-1:0] rsp_out_run,
   output logic [kwm_pkg::KEY_W-1:0] rsp_out_key,
   output logic [kwm_pkg::CNT_W-1:0] rsp_occupancy
);
   import kwm_pkg::*;

`include "k_way_merge_ordered_list_assert.svh"

   logic             req_fire;
   logic             is_pop;
   logic             is_full;
   logic             is_empty;
   kwm_ctl_type      ctl;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic [RUN_W-1:0] out_run_ff, out_run_in;
   logic [KEY_W-1:0] out_key_ff, out_key_in;
   logic [CNT_W-1:0] occ_ff;

   logic [KEY_W-1:0] cell_key   [RUNS];
   logic [RUN_W-1:0] cell_run   [RUNS];
   logic             cell_after [RUNS];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_pop    = (req_cmd == CMD_POP);
   assign is_full   = (count_ff == CNT_W'(RUNS));
   assign is_empty  = (count_ff == '0);

   assign ctl.ins = req_fire && !is_pop && !is_full;
   assign ctl.pop = req_fire && is_pop && !is_empty;

   genvar i;
   generate
      for (i = 0; i < RUNS; i++) begin : g_cell
         logic [KEY_W-1:0] l_key, r_key;
         logic [RUN_W-1:0] l_run, r_run;
         logic             l_after;

         if (i == 0) begin : g_head
            assign l_key   = req_key;
            assign l_run   = req_run_id;
            assign l_after = 1'b1;
         end else begin : g_mid
            assign l_key   = cell_key[i-1];
            assign l_run   = cell_run[i-1];
            assign l_after = cell_after[i-1];
         end

         if (i == RUNS - 1) begin : g_tail
            assign r_key = cell_key[i];
            assign r_run = cell_run[i];
         end else begin : g_body
            assign r_key = cell_key[i+1];
            assign r_run = cell_run[i+1];
         end

         kwm_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .slot_valid (count_ff > CNT_W'(i)),
            .new_key    (req_key),
            .new_run    (req_run_id),
            .left_key   (l_key),
            .left_run   (l_run),
            .left_after (l_after),
            .right_key  (r_key),
            .right_run  (r_run),
            .key        (cell_key[i]),
            .run        (cell_run[i]),
            .after      (cell_after[i])
         );
      end
   endgenerate

   always_comb begin
      count_in     = count_ff;
      status_in    = status_ff;
      out_run_in   = out_run_ff;
      out_key_in   = out_key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (ctl.ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         out_run_in   = '0;
         out_key_in   = '0;
         if (is_pop) begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               status_in  = ST_POPPED;
               out_run_in = cell_run[0];
               out_key_in = cell_key[0];
            end
         end else begin
            status_in = is_full ? ST_FULL : ST_INSERTED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      out_run_ff <= out_run_in;
      out_key_ff <= out_key_in;
      if (req_fire) begin
         occ_ff <= count_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_run   = out_run_ff;
   assign rsp_out_key   = out_key_ff;
   assign rsp_occupancy = occ_ff;

   `KWM_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(RUNS))
   `KWM_ASSERT(a_head_sorted, clock, reset,
      (count_ff >= CNT_W'(2)) |-> (cell_key[0] <= cell_key[1]))
   `KWM_ASSERT(a_pop_count, clock, reset,
      ctl.pop |=> (count_ff == $past(count_ff) - CNT_W'(1)))
   `KWM_ASSERT(a_full_drop, clock, reset,
      (req_fire && !is_pop && is_full) |=> (status_ff == ST_FULL && $stable(count_ff)))
   `KWM_ASSERT(a_occ_match, clock, reset, req_fire |=> (occ_ff == count_ff))

endmodule

@@ verif/tb.sv @@
// testbench for the merge list: insert and pop items checked against a shadow ordered list
`timescale 1ns / 100ps

import kwm_pkg::*;

typedef struct {
   status_type       status;
   logic [RUN_W-1:0] out_run;
   logic [KEY_W-1:0] out_key;
   logic [CNT_W-1:0] occupancy;
} list_result_type;

class merge_scoreboard;
   logic [KEY_W-1:0] shadow_key [RUNS];
   logic [RUN_W-1:0] shadow_run [RUNS];
   int               shadow_count;
   list_result_type  pending_results [$];
   int               errors;
   // last successful pop, used to build merge-like follow-up inserts
   bit               popped_hit;
   logic [RUN_W-1:0] popped_run;
   logic [KEY_W-1:0] popped_key;

   function new();
      shadow_count = 0;
      errors       = 0;
      popped_hit   = 1'b0;
   endfunction

   function void take_cmd(cmd_type cmd, logic [RUN_W-1:0] run_id, logic [KEY_W-1:0] key);
      list_result_type res;
      int              pos;
      res.out_run = '0;
      res.out_key = '0;
      popped_hit  = 1'b0;
      if (cmd == CMD_INSERT) begin
         if (shadow_count >= RUNS) begin
            res.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < shadow_count && key > shadow_key[pos]) pos++;
            for (int i = shadow_count; i > pos; i--) begin
               shadow_key[i] = shadow_key[i-1];
               shadow_run[i] = shadow_run[i-1];
            end
            shadow_key[pos] = key;
            shadow_run[pos] = run_id;
            shadow_count++;
            res.status = ST_INSERTED;
         end
      end else begin
         if (shadow_count == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.out_run = shadow_run[0];
            res.out_key = shadow_key[0];
            for (int i = 0; i + 1 < shadow_count; i++) begin
               shadow_key[i] = shadow_key[i+1];
               shadow_run[i] = shadow_run[i+1];
            end
            shadow_count--;
            res.status = ST_POPPED;
            popped_hit = 1'b1;
            popped_run = res.out_run;
            popped_key = res.out_key;
         end
      end
      res.occupancy = shadow_count[CNT_W-1:0];
      pending_results.push_back(res);
   endfunction

   function void check_result(logic [1:0] status, logic [RUN_W-1:0] out_run,
                              logic [KEY_W-1:0] out_key, logic [CNT_W-1:0] occupancy);
      list_result_type exp_res;
      if (pending_results.size() == 0) begin
         $display("%0t: unexpected result status %0d run %0d key %h occupancy %0d",
                  $time, status, out_run, out_key, occupancy);
         errors++;
         return;
      end
      exp_res = pending_results.pop_front();
      if (status !== exp_res.status) begin
         $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status);
         errors++;
      end
      if (out_run !== exp_res.out_run) begin
         $display("%0t: out_run expected %0d actual %0d", $time, exp_res.out_run, out_run);
         errors++;
      end
      if (out_key !== exp_res.out_key) begin
         $display("%0t: out_key expected %h actual %h", $time, exp_res.out_key, out_key);
         errors++;
      end
      if (occupancy !== exp_res.occupancy) begin
         $display("%0t: occupancy expected %0d actual %0d", $time, exp_res.occupancy,
                  occupancy);
         errors++;
      end
   endfunction
endclass

module tb;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASE_ITEMS  = 250;

   logic                 clock;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_ready;
   logic                 req_cmd       = CMD_INSERT;
   logic [RUN_W-1:0]     req_run_id    = '0;
   logic [KEY_W-1:0]     req_key       = '0;
   logic                 rsp_valid;
   logic                 rsp_ready     = 1'b0;
   logic [1:0]           rsp_status;
   logic [RUN_W-1:0]     rsp_out_run;
   logic [KEY_W-1:0]     rsp_out_key;
   logic [CNT_W-1:0]     rsp_occupancy;

   int                   cycle_count   = 0;
   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   int                   stall_ask     = 0;
   int                   stall_seen    = 0;
   int                   hold_left     = 0;
   merge_scoreboard      sb            = new();

   k_way_merge_ordered_list i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_run_id    (req_run_id),
      .req_key       (req_key),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_out_run   (rsp_out_run),
      .rsp_out_key   (rsp_out_key),
      .rsp_occupancy (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: check accepted results, random ready, long hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_status, rsp_out_run, rsp_out_key, rsp_occupancy);
      if (stall_ask != stall_seen) begin
         stall_seen <= stall_ask;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic send_item(cmd_type cmd, logic [RUN_W-1:0] run_id, logic [KEY_W-1:0] key);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= cmd;
      req_run_id <= run_id;
      req_key    <= key;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.take_cmd(cmd, run_id, key);
   endtask

   // called right after an accepted item, so at least one result is still due
   task automatic wait_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_results.size() != 0);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 3))
         0:       return {$urandom, $urandom};
         1:       return KEY_W'($urandom_range(0, 7));      // dense values force ties
         2:       return '1 - KEY_W'($urandom_range(0, 3));
         default: return {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
   endfunction

   initial begin
      logic [KEY_W-1:0] key;
      logic [RUN_W-1:0] run_id;
      int               r;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 24;
      recv_idle_pct = 66;

      // directed: pop on empty, extreme and tied keys, duplicate runs, fill, drop on full
      send_item(CMD_POP, 4'd0, '0);
      send_item(CMD_INSERT, 4'd0, '0);
      send_item(CMD_INSERT, 4'd15, '1);
      send_item(CMD_INSERT, 4'd3, 64'd100);
      send_item(CMD_INSERT, 4'd7, 64'd100);
      send_item(CMD_INSERT, 4'd15, 64'd100);
      send_item(CMD_INSERT, 4'd1, 64'h8000_0000_0000_0000);
      send_item(CMD_INSERT, 4'd2, 64'd1);
      send_item(CMD_INSERT, 4'd4, '1);
      send_item(CMD_INSERT, 4'd5, '0);
      send_item(CMD_INSERT, 4'd6, 64'h5555_5555_5555_5555);
      send_item(CMD_INSERT, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA);
      send_item(CMD_INSERT, 4'd9, 64'h7FFF_FFFF_FFFF_FFFF);
      send_item(CMD_INSERT, 4'd10, 64'd99);
      send_item(CMD_INSERT, 4'd11, 64'd101);
      send_item(CMD_INSERT, 4'd12, {$urandom, $urandom});
      send_item(CMD_INSERT, 4'd13, {$urandom, $urandom});
      send_item(CMD_INSERT, 4'd14, 64'd50);
      repeat (5) send_item(CMD_POP, 4'd15, '1);
      wait_drain();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 24; recv_idle_pct = 66; end
            1: begin send_idle_pct = 66; recv_idle_pct = 24; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == 100 && phase != 1) stall_ask <= stall_ask + 1;
            if (n == 180) wait_drain();
            r = $urandom_range(0, 99);
            if (sb.popped_hit && r < 75) begin
               // merge step: the popped run supplies its next, not smaller key
               case ($urandom_range(0, 2))
                  0:       key = sb.popped_key;
                  1:       key = sb.popped_key + KEY_W'($urandom_range(1, 16));
                  default: key = sb.popped_key + {32'd0, $urandom};
               endcase
               if (key < sb.popped_key) key = '1;
               send_item(CMD_INSERT, sb.popped_run, key);
            end else if (sb.popped_hit && r < 80) begin
               send_item(CMD_POP, RUN_W'($urandom), {$urandom, $urandom}); // run exhausted
            end else begin
               run_id = RUN_W'($urandom_range(0, 15));
               key    = pick_key();
               if (sb.shadow_count == 0)
                  r = $urandom_range(0, 99) < 85 ? 0 : 1;
               else if (sb.shadow_count == RUNS)
                  r = $urandom_range(0, 99) < 20 ? 0 : 1;
               else
                  r = $urandom_range(0, 99) < 55 ? 0 : 1;
               send_item(r == 0 ? CMD_INSERT : CMD_POP, run_id, key);
            end
         end
         wait_drain();
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
